FILE: hw/rtl/lrupr_pkg.sv
package lrupr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;
    localparam int SLOT_W     = $clog2(MAX_FRAMES);
    localparam int RANK_W     = $clog2(MAX_FRAMES);
    localparam int CFG_W      = 4;
    localparam int TOTAL_W    = 32;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(3);

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic [RANK_W-1:0]    rank;
    } scan_entry_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              empty;
        logic [SLOT_W-1:0] empty_slot;
        logic [RANK_W-1:0] best_rank;
        logic [SLOT_W-1:0] best_slot;
    } scan_res_t;

endpackage

FILE: hw/rtl/lrupr_if.sv
interface lrupr_in_if
    import lrupr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, action, page_number, input ready);
    modport sink   (input valid, action, page_number, output ready);
endinterface

interface lrupr_out_if
    import lrupr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 fault;
    logic [2:0]           frame_slot;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [TOTAL_W-1:0]   fault_total;

    modport source (output valid, fault, frame_slot, evicted_valid, evicted_page, fault_total,
                    input ready);
    modport sink   (input valid, fault, frame_slot, evicted_valid, evicted_page, fault_total,
                    output ready);
endinterface

FILE: hw/rtl/lrupr_scan.sv
module lrupr_scan
    import lrupr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 first,
    input  logic [SLOT_W-1:0]    idx,
    input  scan_entry_t          entry,
    input  logic [PAGE_BITS-1:0] ref_page,
    output scan_res_t            res
);

    scan_res_t res_reg;
    scan_res_t res_next;
    scan_res_t base;

    always_comb
    begin
        base = res_reg;
        if (first)
        begin
            base.hit   = 1'b0;
            base.empty = 1'b0;
        end
        res_next = base;
        if (!base.hit && entry.valid && entry.page == ref_page)
        begin
            res_next.hit      = 1'b1;
            res_next.hit_slot = idx;
        end
        if (!base.empty && !entry.valid)
        begin
            res_next.empty      = 1'b1;
            res_next.empty_slot = idx;
        end
        if (first || entry.rank > base.best_rank)
        begin
            res_next.best_rank = entry.rank;
            res_next.best_slot = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: hw/rtl/lru_page_replacement.sv
// A reference is scanned over the n active frames (1..8), then updated; a restart goes
// straight to update. The compare unit scans one frame per cycle; the update waits while
// the output holds an unaccepted result. refs.ready is high only while idle: one item at a time.
// A finished result waits in the output register while the next item is scanned.
// Reset: frames empty, ranks and fault total zero, frames_reg = 3; frame pages not cleared.
module lru_page_replacement
    import lrupr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    lrupr_in_if.sink            refs,
    lrupr_out_if.source         results,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CFG_W-1:0]     frames_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic                 restart_reg;
    logic [PAGE_BITS-1:0] page_reg;

    logic [PAGE_BITS-1:0] frame_page_reg [MAX_FRAMES];
    logic                 frame_valid_reg [MAX_FRAMES];
    logic                 frame_valid_next [MAX_FRAMES];
    logic [RANK_W-1:0]    rank_reg [MAX_FRAMES];
    logic [RANK_W-1:0]    rank_next [MAX_FRAMES];
    logic [TOTAL_W-1:0]   total_reg, total_next;

    logic                 out_valid_reg;
    logic                 fault_reg;
    logic [2:0]           slot_reg;
    logic                 evicted_valid_reg;
    logic [PAGE_BITS-1:0] evicted_page_reg;

    logic [CFG_W-1:0]     n_act;
    logic                 scan_last;
    logic                 fire;
    scan_entry_t          entry;
    scan_res_t            scan;
    logic [SLOT_W-1:0]    sel_slot;
    logic                 do_fault;
    logic                 do_evict;
    logic                 do_fill;
    logic [RANK_W:0]      limit;

    always_comb
    begin
        priority if (frames_reg == '0)
            n_act = CFG_W'(1);
        else if (frames_reg > CFG_W'(MAX_FRAMES))
            n_act = CFG_W'(MAX_FRAMES);
        else
            n_act = frames_reg;
    end

    assign scan_last = ({{(CFG_W-SLOT_W){1'b0}}, idx_reg} == n_act - CFG_W'(1));
    assign fire      = (state_reg == ST_UPDATE) && (!out_valid_reg || results.ready);

    assign refs.ready = (state_reg == ST_IDLE);

    assign entry.valid = frame_valid_reg[idx_reg];
    assign entry.page  = frame_page_reg[idx_reg];
    assign entry.rank  = rank_reg[idx_reg];

    lrupr_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (state_reg == ST_SCAN),
        .first    (idx_reg == '0),
        .idx      (idx_reg),
        .entry    (entry),
        .ref_page (page_reg),
        .res      (scan)
    );

    always_comb
    begin
        sel_slot = scan.best_slot;
        do_fault = 1'b1;
        do_evict = 1'b0;
        do_fill  = 1'b0;
        limit    = {1'b0, rank_reg[scan.best_slot]};
        priority if (scan.hit)
        begin
            sel_slot = scan.hit_slot;
            do_fault = 1'b0;
            limit    = {1'b0, rank_reg[scan.hit_slot]};
        end
        else if (scan.empty)
        begin
            sel_slot = scan.empty_slot;
            do_fill  = 1'b1;
            limit    = (RANK_W+1)'(MAX_FRAMES);
        end
        else
        begin
            do_evict = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            frame_valid_next[i] = frame_valid_reg[i];
            rank_next[i]        = rank_reg[i];
            if (restart_reg)
            begin
                frame_valid_next[i] = 1'b0;
                rank_next[i]        = '0;
            end
            else if (SLOT_W'(i) == sel_slot)
            begin
                rank_next[i] = '0;
                if (do_fill)
                    frame_valid_next[i] = 1'b1;
            end
            else if (frame_valid_reg[i] && {1'b0, rank_reg[i]} < limit &&
                     rank_reg[i] != RANK_W'(MAX_FRAMES - 1))
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
        priority if (restart_reg)
            total_next = '0;
        else if (do_fault && total_reg != '1)
            total_next = total_reg + TOTAL_W'(1);
        else
            total_next = total_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (refs.valid)
                    state_next = refs.action ? ST_UPDATE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frames_reg    <= FRAMES_RESET;
            idx_reg       <= '0;
            restart_reg   <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                frame_valid_reg[i] <= 1'b0;
                rank_reg[i]        <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                frames_reg <= cfg_wdata;
            if (refs.valid && refs.ready)
            begin
                idx_reg     <= '0;
                restart_reg <= refs.action;
            end
            else if (state_reg == ST_SCAN && !scan_last)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (fire)
            begin
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
                for (int i = 0; i < MAX_FRAMES; i++)
                begin
                    frame_valid_reg[i] <= frame_valid_next[i];
                    rank_reg[i]        <= rank_next[i];
                end
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (refs.valid && refs.ready)
            page_reg <= refs.page_number;
        if (fire && !restart_reg && do_fault)
            frame_page_reg[sel_slot] <= page_reg;
        if (fire)
        begin
            fault_reg         <= !restart_reg && do_fault;
            slot_reg          <= restart_reg ? 3'd0 : 3'(sel_slot);
            evicted_valid_reg <= !restart_reg && do_evict;
            evicted_page_reg  <= (!restart_reg && do_evict) ? frame_page_reg[sel_slot] : '0;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.fault         = fault_reg;
    assign results.frame_slot    = slot_reg;
    assign results.evicted_valid = evicted_valid_reg;
    assign results.evicted_page  = evicted_page_reg;
    assign results.fault_total   = total_reg;

endmodule

FILE: tb/tb_lru_page_replacement.sv
module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam logic ACT_REF      = 1'b0;
    localparam logic ACT_RESTART  = 1'b1;
    localparam int   RANDOM_ITEMS = 1300;
    localparam int   STALL_LIMIT  = 3000;
    localparam int   PRINT_CAP    = 40;

    typedef struct packed {
        logic                 fault;
        logic [2:0]           slot;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
        logic [TOTAL_W-1:0]   total;
    } page_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lrupr_in_if  refs_if();
    lrupr_out_if res_if();

    lru_page_replacement i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .refs      (refs_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // frame table tracker
    bit [PAGE_BITS-1:0] frame_tag  [MAX_FRAMES];
    bit                 frame_busy [MAX_FRAMES];
    bit [RANK_W-1:0]    frame_age  [MAX_FRAMES];
    bit [TOTAL_W-1:0]   faults_since_restart;
    bit [CFG_W-1:0]     frames_setting;

    page_result_t pending_results [$];

    bit idle_src = 1'b1;
    bit idle_snk = 1'b1;
    int hold_cycles;
    int quiet_cycles;
    int mismatches;
    int results_seen;
    int items_sent;
    int hit_count;
    int fault_count;
    int evict_count;
    int restart_count;
    int config_writes;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_frames();
        int i;
        for (i = 0; i < MAX_FRAMES; i++)
        begin
            frame_busy[i] = 1'b0;
            frame_age[i]  = '0;
        end
        faults_since_restart = '0;
    endfunction

    function automatic void make_recent(input int f, input int limit);
        int i;
        for (i = 0; i < MAX_FRAMES; i++)
        begin
            if (i != f && frame_busy[i] && int'(frame_age[i]) < limit &&
                int'(frame_age[i]) < MAX_FRAMES - 1)
                frame_age[i]++;
        end
        frame_age[f] = '0;
    endfunction

    function automatic page_result_t lru_lookup(input logic act,
                                                input logic [PAGE_BITS-1:0] page);
        page_result_t r;
        int n, i, slot, oldest;
        bit found, empty;
        r = '0;
        if (frames_setting == 0)
            n = 1;
        else if (frames_setting > MAX_FRAMES)
            n = MAX_FRAMES;
        else
            n = int'(frames_setting);
        if (act == ACT_RESTART)
        begin
            clear_frames();
            return r;
        end
        found = 1'b0;
        slot  = 0;
        for (i = 0; i < n; i++)
        begin
            if (!found && frame_busy[i] && frame_tag[i] == page)
            begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            make_recent(slot, int'(frame_age[slot]));
            r.slot  = slot[2:0];
            r.total = faults_since_restart;
            return r;
        end
        r.fault = 1'b1;
        empty   = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (!empty && !frame_busy[i])
            begin
                slot  = i;
                empty = 1'b1;
            end
        end
        if (empty)
        begin
            make_recent(slot, MAX_FRAMES);
            frame_busy[slot] = 1'b1;
        end
        else
        begin
            oldest = 0;
            slot   = 0;
            for (i = 0; i < n; i++)
            begin
                if (i == 0 || int'(frame_age[i]) > oldest)
                begin
                    oldest = int'(frame_age[i]);
                    slot   = i;
                end
            end
            r.ev_valid = 1'b1;
            r.ev_page  = frame_tag[slot];
            make_recent(slot, int'(frame_age[slot]));
        end
        frame_tag[slot] = page;
        if (faults_since_restart != '1)
            faults_since_restart++;
        r.slot  = slot[2:0];
        r.total = faults_since_restart;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at result %0d: %s got %0h want %0h",
                     results_seen, what, got, want);
    endtask

    task automatic check_result();
        page_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with nothing pending", '0, '0);
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        if (res_if.fault !== want.fault)
            report_mismatch("fault", 64'(res_if.fault), 64'(want.fault));
        if (res_if.frame_slot !== want.slot)
            report_mismatch("frame_slot", 64'(res_if.frame_slot), 64'(want.slot));
        if (res_if.evicted_valid !== want.ev_valid)
            report_mismatch("evicted_valid", 64'(res_if.evicted_valid), 64'(want.ev_valid));
        if (res_if.evicted_page !== want.ev_page)
            report_mismatch("evicted_page", 64'(res_if.evicted_page), 64'(want.ev_page));
        if (res_if.fault_total !== want.total)
            report_mismatch("fault_total", 64'(res_if.fault_total), 64'(want.total));
    endtask

    always @(posedge clk)
    begin
        if (res_if.valid && res_if.ready)
            check_result();
    end

    always @(posedge clk)
    begin
        if ((refs_if.valid && refs_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("tb_lru_page_replacement: errors");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = idle_snk ? $urandom_range(0, 9) : 0;
            if (hold_cycles > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid && hold_cycles == 0)
                @(posedge clk);
        end
    end

    task automatic send_ref(input logic act, input logic [PAGE_BITS-1:0] page);
        int gap;
        page_result_t r;
        gap = idle_src ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            refs_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        refs_if.valid       <= 1'b1;
        refs_if.action      <= act;
        refs_if.page_number <= page;
        @(posedge clk);
        while (!refs_if.ready)
            @(posedge clk);
        r = lru_lookup(act, page);
        pending_results = {pending_results, r};
        items_sent++;
        if (act == ACT_RESTART)
            restart_count++;
        else if (!r.fault)
            hit_count++;
        else
            fault_count++;
        if (r.ev_valid)
            evict_count++;
    endtask

    task automatic wait_drained();
        refs_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we         <= 1'b0;
        frames_setting = value;
        config_writes++;
        @(posedge clk);
    endtask

    // reset value of three frames, hits, fill, eviction, restart
    task automatic test_default_frames();
        send_ref(ACT_REF, 16'h0000);
        send_ref(ACT_REF, 16'hFFFF);
        send_ref(ACT_REF, 16'h0000);
        send_ref(ACT_REF, 16'h5555);
        send_ref(ACT_REF, 16'hAAAA);
        send_ref(ACT_REF, 16'h0000);
        send_ref(ACT_RESTART, 16'hFFFF);
        send_ref(ACT_REF, 16'h5555);
    endtask

    // one frame, zero and over-range counts, full eight frames
    task automatic test_frame_extremes();
        int i;
        set_frames(4'd1);
        send_ref(ACT_REF, 16'h1234);
        send_ref(ACT_REF, 16'h1234);
        send_ref(ACT_REF, 16'h4321);
        set_frames(4'd0);
        send_ref(ACT_REF, 16'h1234);
        set_frames(4'd15);
        for (i = 0; i < MAX_FRAMES; i++)
            send_ref(ACT_REF, 16'(i + 32'h8000));
        send_ref(ACT_REF, 16'h7FFF);
    endtask

    // hidden frames keep their pages and come back when the count grows
    task automatic test_shrink_grow();
        set_frames(4'd2);
        send_ref(ACT_REF, 16'h8005);
        set_frames(4'd8);
        send_ref(ACT_REF, 16'h8006);
    endtask

    // receiver holds off while the sender keeps offering, then sender drains
    task automatic test_backpressure();
        int i;
        idle_src    = 1'b0;
        hold_cycles = 150;
        for (i = 0; i < 8; i++)
            send_ref(ACT_REF, 16'($urandom));
        wait_drained();
        idle_src = 1'b1;
    endtask

    task automatic test_random_traffic();
        int remaining, len, pick, ph, k, pool_n;
        logic [CFG_W-1:0]     setting;
        logic [PAGE_BITS-1:0] pool [12];
        remaining = RANDOM_ITEMS;
        ph        = 0;
        while (remaining > 0)
        begin
            case (ph % 6)
                0:       setting = 4'd1;
                1:       setting = 4'(MAX_FRAMES);
                2:       setting = 4'd0;
                3:       setting = 4'd15;
                default: setting = 4'($urandom_range(0, 15));
            endcase
            set_frames(setting);
            idle_src = ($urandom_range(0, 2) != 0);
            idle_snk = ($urandom_range(0, 2) != 0);
            pool_n   = $urandom_range(1, 12);
            for (k = 0; k < pool_n; k++)
                pool[k] = 16'($urandom);
            len = $urandom_range(60, 140);
            if (len > remaining)
                len = remaining;
            for (k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_ref(ACT_RESTART, 16'($urandom));
                else if (pick < 12)
                    send_ref(ACT_REF, 16'($urandom));
                else
                    send_ref(ACT_REF, pool[$urandom_range(0, pool_n - 1)]);
            end
            remaining -= len;
            ph++;
        end
        idle_src = 1'b1;
        idle_snk = 1'b1;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        refs_if.valid       <= 1'b0;
        refs_if.action      <= ACT_REF;
        refs_if.page_number <= '0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        clear_frames();
        frames_setting = FRAMES_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_frames();
        test_frame_extremes();
        test_shrink_grow();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (16) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 64'(pending_results.size()), '0);

        $display("sent %0d items: %0d hits, %0d faults, %0d evictions, %0d restarts",
                 items_sent, hit_count, fault_count, evict_count, restart_count);
        $display("%0d frame-count writes, %0d results checked, %0d mismatches",
                 config_writes, results_seen, mismatches);
        if (mismatches == 0)
            $display("tb_lru_page_replacement: clean");
        else
            $display("tb_lru_page_replacement: errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_if.sv
hw/rtl/lrupr_scan.sv
hw/rtl/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
